>>> src/gtn_pkg.sv
// Package for the triangle grid neighbour block.
// Holds widths, register indexes and the structs shared between the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gtn_pkg;

  localparam int MAX_DIVISIONS = 255;
  localparam int DIV_W    = $clog2(MAX_DIVISIONS + 1);
  localparam int DVS_W    = DIV_W + 1;
  localparam int FW       = 17;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int SW       = DIV_W + 3;
  localparam int PW       = SW + DVS_W + 1;
  localparam int SUMW     = PW + 1;
  localparam int DIV_PER_STG = 2;
  localparam int DIV_STG  = (DIV_W + DIV_PER_STG - 1) / DIV_PER_STG;
  localparam int RST_DIV  = 3;
  localparam int MIN_DIV  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_U_DIV = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_V_DIV = CFG_IDX_W'(1);

  typedef logic signed [SW-1:0] crd_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_ROW,
    K_COL,
    K_DIAG
  } kind_e;

  typedef struct packed {
    logic [DIV_W-1:0] nu;
    logic [DIV_W-1:0] nv;
    logic [DVS_W-1:0] vp1;
    logic [DVS_W-1:0] v2;
    logic [FW-1:0]    npts;
    logic [FW-1:0]    ntri;
  } cfg_t;

  typedef struct packed {
    logic [DIV_W-1:0] lig_p;
    logic [DVS_W-1:0] col_p;
    logic [DIV_W-1:0] lig_e;
    logic [DVS_W-1:0] col_e;
    logic [DIV_W-1:0] row_t;
    logic [DVS_W-1:0] col_t;
    logic             tri_nz;
    logic             edg_nz;
  } div_res_t;

  typedef struct packed {
    crd_t lin_t;
    crd_t col_t;
    crd_t lin_o;
    crd_t col_o;
    logic off;
  } adj_t;

endpackage
`default_nettype wire

>>> src/gtn_if.sv
// Handshake interfaces for the triangle grid neighbour block.
// Query, result and configuration channels; depends on gtn_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface gtn_query_if import gtn_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [FW-1:0] triangle_index;
  logic [FW-1:0] pivot_point;
  logic [FW-1:0] edge_point;
  modport source (output valid, triangle_index, pivot_point, edge_point, input ready);
  modport sink (input valid, triangle_index, pivot_point, edge_point, output ready);
endinterface

interface gtn_result_if import gtn_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [FW-1:0] neighbour_triangle;
  logic [FW-1:0] opposite_point;
  modport source (output valid, neighbour_triangle, opposite_point, input ready);
  modport sink (input valid, neighbour_triangle, opposite_point, output ready);
endinterface

interface gtn_cfg_if import gtn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/gtn_cfg.sv
// Configuration registers of the grid: clamped division counts and derived sizes.
// Depends on gtn_pkg and gtn_cfg_if.
`timescale 1ns / 1ps
`default_nettype none
module gtn_cfg import gtn_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gtn_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  function automatic logic [DIV_W-1:0] clamp_div(input logic [CFG_W-1:0] raw);
    logic [DIV_W-1:0] res;
    if (int'(raw) < MIN_DIV) res = DIV_W'(MIN_DIV);
    else if (int'(raw) > MAX_DIVISIONS) res = DIV_W'(MAX_DIVISIONS);
    else res = DIV_W'(raw);
    return res;
  endfunction

  logic [DIV_W-1:0] nu_q, nu_d, nv_q, nv_d;
  logic [FW-1:0]    npts_q, npts_d, ntri_q, ntri_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    nu_d = nu_q;
    nv_d = nv_q;
    if (cfg_i.valid && cfg_i.index == CFG_U_DIV) nu_d = clamp_div(cfg_i.data);
    if (cfg_i.valid && cfg_i.index == CFG_V_DIV) nv_d = clamp_div(cfg_i.data);
    npts_d = FW'((FW'(nu_d) + FW'(1)) * (FW'(nv_d) + FW'(1)));
    ntri_d = FW'(FW'(nu_d) * (FW'(nv_d) << 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nu_q   <= DIV_W'(RST_DIV);
      nv_q   <= DIV_W'(RST_DIV);
      npts_q <= FW'((RST_DIV + 1) * (RST_DIV + 1));
      ntri_q <= FW'(2 * RST_DIV * RST_DIV);
    end else begin
      nu_q   <= nu_d;
      nv_q   <= nv_d;
      npts_q <= npts_d;
      ntri_q <= ntri_d;
    end
  end

  always_comb begin
    cfg_o.nu   = nu_q;
    cfg_o.nv   = nv_q;
    cfg_o.vp1  = DVS_W'(nv_q) + DVS_W'(1);
    cfg_o.v2   = {nv_q, 1'b0};
    cfg_o.npts = npts_q;
    cfg_o.ntri = ntri_q;
  end

endmodule
`default_nettype wire

>>> src/gtn_div.sv
// Pipelined restoring divider, two quotient bits per stage.
// Divides a point or triangle offset by a row length; depends on gtn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtn_div import gtn_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [FW-1:0]    dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic      [DIV_W-1:0] quotient_o,
  output logic      [DVS_W-1:0] remainder_o
);

  localparam int XW = FW + DIV_W;

  logic [FW-1:0]    rem_q [DIV_STG];
  logic [DIV_W-1:0] quo_q [DIV_STG];

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic [FW-1:0]    rem_in, rem_d;
    logic [DIV_W-1:0] quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = dividend_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [XW-1:0] r;
      logic [XW-1:0] t;
      int k;
      r = XW'(rem_in);
      quo_d = quo_in;
      for (int j = 0; j < DIV_PER_STG; j++) begin
        k = DIV_W - 1 - s * DIV_PER_STG - j;
        if (k >= 0) begin
          t = XW'(divisor_i) << k;
          if (r >= t) begin
            r = r - t;
            quo_d[k] = 1'b1;
          end
        end
      end
      rem_d = r[FW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quotient_o  = quo_q[DIV_STG-1];
  assign remainder_o = rem_q[DIV_STG-1][DVS_W-1:0];

endmodule
`default_nettype wire

>>> src/gtn_adj.sv
// Adjacency decision and grid boundary correction, two register stages.
// Works on row and column coordinates; depends on gtn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtn_adj import gtn_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     en_i,
  input  wire cfg_t     cfg_i,
  input  wire div_res_t div_i,
  output adj_t          adj_o
);

  function automatic crd_t smax(input crd_t a, input crd_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic crd_t smin(input crd_t a, input crd_t b);
    return (a < b) ? a : b;
  endfunction

  crd_t lt_d, ct_d, lo_d, co_d, lp_d, cp_d, le_d, ce_d;
  crd_t lt_q, ct_q, lo_q, co_q, lp_q, cp_q, le_q, ce_q;
  adj_t adj_d, adj_q;

  always_comb begin
    kind_e k;
    crd_t  tmp;
    lp_d = $signed({{(SW-DIV_W){1'b0}}, div_i.lig_p});
    cp_d = $signed({{(SW-DVS_W){1'b0}}, div_i.col_p});
    le_d = $signed({{(SW-DIV_W){1'b0}}, div_i.lig_e});
    ce_d = $signed({{(SW-DVS_W){1'b0}}, div_i.col_e});
    lt_d = $signed({{(SW-DIV_W){1'b0}}, div_i.row_t}) + crd_t'(1);
    ct_d = $signed({{(SW-DVS_W){1'b0}}, div_i.col_t}) + crd_t'(1);
    lo_d = '0;
    co_d = '0;
    if (!div_i.edg_nz) k = K_NONE;
    else if (lp_d == le_d) k = K_ROW;
    else if (cp_d == ce_d) k = K_COL;
    else k = K_DIAG;

    if (div_i.tri_nz) begin
      if (k == K_NONE) begin
        if (lp_d == lt_d) begin
          le_d = lp_d - crd_t'(1);
          ce_d = cp_d - crd_t'(1);
          k = K_DIAG;
        end else if (ct_d == lp_d + lp_d) begin
          le_d = lp_d;
          ce_d = cp_d - crd_t'(1);
          k = K_ROW;
        end else begin
          le_d = lp_d + crd_t'(1);
          ce_d = cp_d + crd_t'(1);
          k = K_DIAG;
        end
      end
      case (k)
        K_ROW: begin
          if (lt_d == lp_d) begin
            lt_d = lt_d + crd_t'(1);
            lo_d = lp_d + crd_t'(1);
            co_d = smax(cp_d, ce_d);
          end else begin
            lt_d = lt_d - crd_t'(1);
            lo_d = lp_d - crd_t'(1);
            co_d = smin(cp_d, ce_d);
          end
        end
        K_COL: begin
          if (ct_d == cp_d + cp_d) begin
            ct_d = ct_d + crd_t'(1);
            lo_d = smax(lp_d, le_d);
            co_d = cp_d + crd_t'(1);
          end else begin
            ct_d = ct_d - crd_t'(1);
            lo_d = smin(lp_d, le_d);
            co_d = cp_d - crd_t'(1);
          end
        end
        default: begin
          if (!ct_d[0]) begin
            ct_d = ct_d - crd_t'(1);
            lo_d = smax(lp_d, le_d);
            co_d = smin(cp_d, ce_d);
          end else begin
            ct_d = ct_d + crd_t'(1);
            lo_d = smin(lp_d, le_d);
            co_d = smax(cp_d, ce_d);
          end
        end
      endcase
    end else begin
      case (k)
        K_NONE: begin
          lt_d = smax(crd_t'(1), lp_d);
          ct_d = smax(crd_t'(1), cp_d + cp_d);
          lo_d = (lp_d == '0) ? crd_t'(1) : lp_d - crd_t'(1);
          co_d = cp_d;
        end
        K_ROW: begin
          tmp  = smax(cp_d, ce_d);
          lt_d = lp_d + crd_t'(1);
          lo_d = lp_d + crd_t'(1);
          co_d = tmp;
          ct_d = tmp + tmp;
        end
        K_COL: begin
          lt_d = smax(lp_d, le_d);
          ct_d = cp_d + cp_d;
          lo_d = smin(lp_d, le_d);
          co_d = cp_d - crd_t'(1);
        end
        default: begin
          lt_d = smax(lp_d, le_d);
          ct_d = cp_d + ce_d;
          lo_d = lt_d;
          co_d = smin(cp_d, ce_d);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lt_q <= lt_d;
      ct_q <= ct_d;
      lo_q <= lo_d;
      co_q <= co_d;
      lp_q <= lp_d;
      cp_q <= cp_d;
      le_q <= le_d;
      ce_q <= ce_d;
    end
  end

  always_comb begin
    crd_t nu, nv;
    nu = $signed({{(SW-DIV_W){1'b0}}, cfg_i.nu});
    nv = $signed({{(SW-DIV_W){1'b0}}, cfg_i.nv});
    adj_d.lin_t = lt_q;
    adj_d.col_t = ct_q;
    adj_d.lin_o = lo_q;
    adj_d.col_o = co_q;
    adj_d.off   = 1'b0;
    if (lt_q < crd_t'(1)) begin
      adj_d.lin_o = '0;
      adj_d.col_o = cp_q + cp_q - ce_q;
      if (adj_d.col_o < crd_t'(0)) begin
        adj_d.col_o = '0;
        adj_d.lin_o = crd_t'(1);
      end else if (adj_d.col_o > nv) begin
        adj_d.col_o = nv;
        adj_d.lin_o = crd_t'(1);
      end
      adj_d.off = 1'b1;
    end else if (lt_q > nu) begin
      adj_d.lin_o = nu;
      adj_d.col_o = cp_q + cp_q - ce_q;
      if (adj_d.col_o < crd_t'(0)) begin
        adj_d.col_o = '0;
        adj_d.lin_o = nu - crd_t'(1);
      end else if (adj_d.col_o > nv) begin
        adj_d.col_o = nv;
        adj_d.lin_o = nu - crd_t'(1);
      end
      adj_d.off = 1'b1;
    end
    if (ct_q < crd_t'(1)) begin
      adj_d.col_o = '0;
      adj_d.lin_o = lp_q + lp_q - le_q;
      if (adj_d.lin_o < crd_t'(0)) begin
        adj_d.lin_o = '0;
        adj_d.col_o = crd_t'(1);
      end else if (adj_d.lin_o > nu) begin
        adj_d.lin_o = nu;
        adj_d.col_o = crd_t'(1);
      end
      adj_d.off = 1'b1;
    end else if (ct_q > nv) begin
      adj_d.col_o = nv;
      adj_d.lin_o = lp_q + lp_q - le_q;
      if (adj_d.lin_o < crd_t'(0)) begin
        adj_d.lin_o = '0;
        adj_d.col_o = nv - crd_t'(1);
      end else if (adj_d.lin_o > nu) begin
        adj_d.lin_o = nu;
        adj_d.col_o = nv - crd_t'(1);
      end
      adj_d.off = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) adj_q <= adj_d;
  end

  assign adj_o = adj_q;

endmodule
`default_nettype wire

>>> src/grid_triangle_neighbour.sv
// Triangle grid neighbour: top level with input clamp, dividers, adjacency and index build.
// Register stages: one input stage, four divider stages, two adjacency stages,
// one multiply stage and the output register. One request per cycle is accepted while not stalled.
// The whole pipeline stalls together only while the output register holds an untaken result.
// Reset empties the pipeline and sets both division counts to 3.
// Depends on gtn_pkg, gtn_if, gtn_cfg, gtn_div and gtn_adj.
`timescale 1ns / 1ps
`default_nettype none
module grid_triangle_neighbour import gtn_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gtn_query_if.sink   query_i,
  gtn_result_if.source result_o,
  gtn_cfg_if.sink     cfg_i
);

  localparam int NSTG = DIV_STG + 5;
  localparam int LAST = NSTG - 1;

  cfg_t     cfg;
  logic     en;
  logic     vld_q [NSTG];
  logic [1:0] flg_q [DIV_STG+1];

  logic [FW-1:0] tri_c, piv_c, edg_c;
  logic [FW-1:0] dvd_p_q, dvd_e_q, dvd_t_q;

  div_res_t div_res;
  adj_t     adj;

  logic signed [PW-1:0] prod_nb_q, prod_op_q;
  crd_t                 col_t_q, col_o_q;
  logic                 off_q;
  logic [FW-1:0]        nb_q, op_q;

  gtn_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign en            = !vld_q[LAST] || result_o.ready;
  assign query_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= query_i.valid;
      for (int i = 1; i < NSTG; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_comb begin
    tri_c = (query_i.triangle_index > cfg.ntri) ? cfg.ntri : query_i.triangle_index;
    if (query_i.pivot_point == '0) piv_c = FW'(1);
    else if (query_i.pivot_point > cfg.npts) piv_c = cfg.npts;
    else piv_c = query_i.pivot_point;
    edg_c = (query_i.edge_point > cfg.npts) ? cfg.npts : query_i.edge_point;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvd_p_q  <= piv_c - FW'(1);
      dvd_e_q  <= (edg_c != '0) ? edg_c - FW'(1) : '0;
      dvd_t_q  <= (tri_c != '0) ? tri_c - FW'(1) : '0;
      flg_q[0] <= {tri_c != '0, edg_c != '0};
      for (int i = 1; i <= DIV_STG; i++) flg_q[i] <= flg_q[i-1];
    end
  end

  gtn_div u_div_p (
    .clk_i       (clk_i),
    .en_i        (en),
    .dividend_i  (dvd_p_q),
    .divisor_i   (cfg.vp1),
    .quotient_o  (div_res.lig_p),
    .remainder_o (div_res.col_p)
  );

  gtn_div u_div_e (
    .clk_i       (clk_i),
    .en_i        (en),
    .dividend_i  (dvd_e_q),
    .divisor_i   (cfg.vp1),
    .quotient_o  (div_res.lig_e),
    .remainder_o (div_res.col_e)
  );

  gtn_div u_div_t (
    .clk_i       (clk_i),
    .en_i        (en),
    .dividend_i  (dvd_t_q),
    .divisor_i   (cfg.v2),
    .quotient_o  (div_res.row_t),
    .remainder_o (div_res.col_t)
  );

  assign div_res.tri_nz = flg_q[DIV_STG][1];
  assign div_res.edg_nz = flg_q[DIV_STG][0];

  gtn_adj u_adj (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg),
    .div_i (div_res),
    .adj_o (adj)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_nb_q <= (adj.lin_t - crd_t'(1)) * $signed({1'b0, cfg.v2});
      prod_op_q <= adj.lin_o * $signed({1'b0, cfg.vp1});
      col_t_q   <= adj.col_t;
      col_o_q   <= adj.col_o;
      off_q     <= adj.off;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [SUMW-1:0] s_nb, s_op, lim_nb, lim_op;
    s_nb   = SUMW'(prod_nb_q) + SUMW'(col_t_q);
    s_op   = SUMW'(prod_op_q) + SUMW'(col_o_q) + SUMW'(1);
    lim_nb = SUMW'($signed({1'b0, cfg.ntri}));
    lim_op = SUMW'($signed({1'b0, cfg.npts}));
    if (en) begin
      if (off_q || s_nb < 0) nb_q <= '0;
      else if (s_nb > lim_nb) nb_q <= cfg.ntri;
      else nb_q <= s_nb[FW-1:0];
      if (s_op < 0) op_q <= '0;
      else if (s_op > lim_op) op_q <= cfg.npts;
      else op_q <= s_op[FW-1:0];
    end
  end

  assign result_o.valid              = vld_q[LAST];
  assign result_o.neighbour_triangle = nb_q;
  assign result_o.opposite_point     = op_q;

  a_nb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.neighbour_triangle <= cfg.ntri)
    else $error("neighbour triangle beyond triangle count");

  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.opposite_point <= cfg.npts)
    else $error("opposite point beyond point count");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |-> !query_i.ready)
    else $error("request taken while output is stalled");

  a_cfg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cfg.nu) >= MIN_DIV) && (int'(cfg.nu) <= MAX_DIVISIONS) &&
    (int'(cfg.nv) >= MIN_DIV) && (int'(cfg.nv) <= MAX_DIVISIONS))
    else $error("division count outside clamp range");

endmodule
`default_nettype wire

>>> verif/tb_gtn_if.sv
// Testbench copies of the handshake interfaces are not needed; the design's
// interfaces from gtn_if are used directly. This file holds shared test types.
// Depends on gtn_pkg.
`timescale 1ns / 1ps
package tb_gtn_types_pkg;
  import gtn_pkg::*;

  typedef struct packed {
    logic [FW-1:0] tri_idx;
    logic [FW-1:0] piv;
    logic [FW-1:0] edg;
  } query_t;

  typedef struct packed {
    logic [FW-1:0] nb;
    logic [FW-1:0] op;
  } answer_t;
endpackage

>>> verif/tb_grid_triangle_neighbour.sv
// Testbench for grid_triangle_neighbour: directed table plus random queries,
// checked against an in-bench adjacency predictor with random idling on both sides.
// Depends on gtn_pkg, gtn_if, tb_gtn_types_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_grid_triangle_neighbour;
  import gtn_pkg::*;
  import tb_gtn_types_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  gtn_query_if  qry ();
  gtn_result_if res ();
  gtn_cfg_if    cfg ();

  grid_triangle_neighbour u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .query_i(qry.sink), .result_o(res.source), .cfg_i(cfg.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb_grid_triangle_neighbour: done, errors");
    $finish;
  end

  logic [CFG_W-1:0] u_reg, v_reg;
  answer_t adj_q[$];
  int errors = 0;
  bit rx_idle_on = 1'b1;

  logic [CFG_W-1:0] settings[6][2] = '{
    '{8'd0, 8'd255}, '{8'd255, 8'd3}, '{8'd255, 8'd255}, '{8'd7, 8'd2},
    '{8'd4, 8'd5}, '{8'hAA, 8'h55}};

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic answer_t neighbour_of(query_t q);
    longint nu, nv, vp1, v2, npts, ntri, t, p, e;
    longint lp, cp, le, ce, kind, lt, ct, lo, co, nb, op, r;
    answer_t a;
    nu = u_reg < 3 ? 3 : u_reg;
    nv = v_reg < 3 ? 3 : v_reg;
    vp1 = nv + 1; v2 = 2 * nv; npts = (nu + 1) * vp1; ntri = nu * v2;
    t = q.tri_idx; p = q.piv; e = q.edg;
    if (t > ntri) t = ntri;
    if (p < 1) p = 1;
    if (p > npts) p = npts;
    if (e > npts) e = npts;
    lp = (p - 1) / vp1; cp = (p - 1) - lp * vp1;
    le = 0; ce = 0; kind = 0;
    if (e != 0) begin
      le = (e - 1) / vp1; ce = (e - 1) - le * vp1;
      kind = (lp == le) ? 1 : (cp == ce) ? 2 : 3;
    end
    lt = 0; ct = 0; lo = 0; co = 0;
    if (t != 0) begin
      r = (t - 1) / v2; lt = 1 + r; ct = 1 + (t - 1) - r * v2;
      if (kind == 0) begin
        if (lp == lt) begin
          le = lp - 1; ce = cp - 1; kind = 3;
        end else if (ct == 2 * lp) begin
          le = lp; ce = cp - 1; kind = 1;
        end else begin
          le = lp + 1; ce = cp + 1; kind = 3;
        end
      end
      if (kind == 1) begin
        if (lt == lp) begin
          lt++; lo = lp + 1; co = lmax(cp, ce);
        end else begin
          lt--; lo = lp - 1; co = lmin(cp, ce);
        end
      end else if (kind == 2) begin
        if (ct == 2 * cp) begin
          ct++; lo = lmax(lp, le); co = cp + 1;
        end else begin
          ct--; lo = lmin(lp, le); co = cp - 1;
        end
      end else begin
        if (ct % 2 == 0) begin
          ct--; lo = lmax(lp, le); co = lmin(cp, ce);
        end else begin
          ct++; lo = lmin(lp, le); co = lmax(cp, ce);
        end
      end
    end else if (e == 0) begin
      lt = lmax(1, lp); ct = lmax(1, 2 * cp);
      lo = (lp == 0) ? 1 : lp - 1; co = cp;
    end else if (kind == 1) begin
      ct = lmax(cp, ce); lt = lp + 1; lo = lp + 1; co = ct; ct = 2 * ct;
    end else if (kind == 2) begin
      lt = lmax(lp, le); ct = 2 * cp; lo = lmin(lp, le); co = cp - 1;
    end else begin
      lt = lmax(lp, le); ct = cp + ce; lo = lt; co = lmin(cp, ce);
    end
    nb = (lt - 1) * v2 + ct;
    if (lt < 1) begin
      lo = 0; co = 2 * cp - ce; nb = 0;
      if (co < 0) begin
        co = 0; lo = 1;
      end else if (co > nv) begin
        co = nv; lo = 1;
      end
    end else if (lt > nu) begin
      lo = nu; co = 2 * cp - ce; nb = 0;
      if (co < 0) begin
        co = 0; lo = nu - 1;
      end else if (co > nv) begin
        co = nv; lo = nu - 1;
      end
    end
    if (ct < 1) begin
      co = 0; lo = 2 * lp - le; nb = 0;
      if (lo < 0) begin
        lo = 0; co = 1;
      end else if (lo > nu) begin
        lo = nu; co = 1;
      end
    end else if (ct > nv) begin
      co = nv; lo = 2 * lp - le; nb = 0;
      if (lo < 0) begin
        lo = 0; co = nv - 1;
      end else if (lo > nu) begin
        lo = nu; co = nv - 1;
      end
    end
    op = lo * vp1 + co + 1;
    nb = lmin(lmax(nb, 0), ntri);
    op = lmin(lmax(op, 0), npts);
    a.nb = FW'(nb);
    a.op = FW'(op);
    return a;
  endfunction

  // The receiver stalls at random unless a calm stretch is running.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= rx_idle_on ? ($urandom_range(99) >= 23) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni && res.valid && res.ready) begin
      if (adj_q.size() == 0) begin
        $display("%0t: result with no request pending: nb %0d op %0d", $time,
                 res.neighbour_triangle, res.opposite_point);
        errors++;
      end else begin
        exp_a = adj_q.pop_front();
        if (res.neighbour_triangle !== exp_a.nb) begin
          $display("%0t: neighbour_triangle expected %0d actual %0d", $time, exp_a.nb,
                   res.neighbour_triangle);
          errors++;
        end
        if (res.opposite_point !== exp_a.op) begin
          $display("%0t: opposite_point expected %0d actual %0d", $time, exp_a.op,
                   res.opposite_point);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    if (idx == CFG_U_DIV) u_reg = val;
    else u_reg = u_reg;
    if (idx == CFG_V_DIV) v_reg = val;
  endtask

  task automatic send_request(query_t q, bit idle_ok);
    while (idle_ok && $urandom_range(99) < 23) begin
      qry.valid <= 1'b0;
      @(posedge clk_i);
    end
    qry.valid          <= 1'b1;
    qry.triangle_index <= q.tri_idx;
    qry.pivot_point    <= q.piv;
    qry.edge_point     <= q.edg;
    do @(posedge clk_i); while (!qry.ready);
    adj_q.push_back(neighbour_of(q));
  endtask

  task automatic drain_results();
    qry.valid <= 1'b0;
    while (adj_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic query_t rand_query();
    query_t q;
    longint npts, ntri;
    npts = ((u_reg < 3 ? 3 : u_reg) + 1) * ((v_reg < 3 ? 3 : v_reg) + 1);
    ntri = 2 * (u_reg < 3 ? 3 : u_reg) * (v_reg < 3 ? 3 : v_reg);
    case ($urandom_range(9))
      0: q = {FW'($urandom), FW'($urandom), FW'($urandom)};
      1: q = {FW'(0), FW'($urandom_range(npts, 1)), FW'(0)};
      2: q = {FW'($urandom_range(ntri, 1)), FW'($urandom_range(npts, 1)), FW'(0)};
      default: q = {FW'($urandom_range(ntri, 0)), FW'($urandom_range(npts, 1)),
                    FW'($urandom_range(npts, 0))};
    endcase
    return q;
  endfunction

  // Directed rows: query and, where obvious, the expected answer (check flag).
  typedef struct {
    query_t  q;
    bit      chk;
    answer_t a;
  } row_t;

  row_t dir_rows[] = '{
    '{'{17'd0, 17'd1, 17'd0}, 1'b1, '{17'd1, 17'd5}},
    '{'{17'd0, 17'd0, 17'd0}, 1'b1, '{17'd1, 17'd5}},
    '{'{17'd0, 17'd16, 17'd0}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd1, 17'd1, 17'd0}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd1, 17'd1, 17'd2}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd1, 17'd1, 17'd5}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd2, 17'd2, 17'd5}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd18, 17'd16, 17'd15}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd6, 17'd4, 17'd8}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd0, 17'd6, 17'd7}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd0, 17'd6, 17'd10}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd0, 17'd6, 17'd11}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd7, 17'd6, 17'd0}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd8, 17'd7, 17'd0}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'd12, 17'd8, 17'd12}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'h15555, 17'h0AAAA, 17'h15555}, 1'b0, '{17'd0, 17'd0}},
    '{'{17'h0AAAA, 17'h15555, 17'h0AAAA}, 1'b0, '{17'd0, 17'd0}}
  };

  initial begin
    query_t q;
    u_reg = CFG_W'(RST_DIV);
    v_reg = CFG_W'(RST_DIV);
    qry.valid <= 1'b0;
    qry.triangle_index <= '0;
    qry.pivot_point <= '0;
    qry.edge_point <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_U_DIV;
    cfg.data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].q, i[0]);
      if (dir_rows[i].chk && neighbour_of(dir_rows[i].q) != dir_rows[i].a) begin
        $display("%0t: row %0d predictor expected %0d/%0d actual %0d/%0d", $time, i,
                 dir_rows[i].a.nb, dir_rows[i].a.op, neighbour_of(dir_rows[i].q).nb,
                 neighbour_of(dir_rows[i].q).op);
        errors++;
      end
    end
    drain_results();

    // Each setting gets a random batch; one batch runs without any idling.
    for (int s = 0; s < 6; s++) begin
      write_reg(CFG_U_DIV, settings[s][0]);
      write_reg(CFG_V_DIV, settings[s][1]);
      cfg.valid <= 1'b0;
      rx_idle_on = (s != 2);
      for (int n = 0; n < 100; n++) begin
        q = rand_query();
        send_request(q, rx_idle_on);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("tb_grid_triangle_neighbour: done, clean");
    end else begin
      $display("tb_grid_triangle_neighbour: done, errors");
    end
    $finish;
  end
endmodule
